FILE: rtl/kdpq_pkg.sv
package kdpq_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_HANDLE_BITS = 32;

  localparam int IN_HANDLE_W  = 32;
  localparam int OUT_HANDLE_W = 32;
  localparam int OCC_W        = 6;
  localparam int LIMIT_W      = 5;

  localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 5'd31;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_SIZE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_POPPED  = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_DROPPED = 3'd3,
    KIND_CLEARED = 3'd4
  } kind_t;

  typedef struct packed {
    action_t                 action;
    logic [IN_HANDLE_W-1:0]  packet_handle;
    logic                    key_flag;
  } in_item_t;

  typedef struct packed {
    kind_t                   result_kind;
    logic [OUT_HANDLE_W-1:0] out_handle;
    logic                    out_key;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;
  } out_item_t;

endpackage

FILE: rtl/keyframe_drop_packet_queue.sv
// Packet descriptor queue with overflow dropping to the next key frame.
//
// Input channel (in_valid / in_stall / in_data): one command item per
// handshake: push, pop, clear or size query. Result channel (out_valid /
// out_stall / out_data): one or more result items per command; the last
// one carries last = 1. Config channel (cfg_valid / cfg_ready / cfg_data)
// writes the occupancy limit; it is always ready.
//
// Commands are handled one at a time; in_stall is high while a command is
// in progress. Push without overflow, pop on empty, clear on empty and
// size query pass through S_ACK, which registers their result item. A pop
// reads the descriptor memory first (S_RD, then S_RET). An overflow drop or
// a clear of a non-empty queue walks the queue head through the single read
// port of the memory, one entry per cycle while the result side does not
// stall; it ends with an ack item, also when a drop stops at a key frame.
// A stall on the result side simply holds the walk; nothing is lost.
//
// Reset clears the pointers, the occupancy and the limit (back to 31);
// the descriptor memory itself is not cleared, so no clearing pass is run.
module keyframe_drop_packet_queue
  import kdpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW  = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;
  localparam int MEM_W = HANDLE_BITS + 1;

  localparam logic [PW-1:0]   LAST_SLOT = PW'(QUEUE_DEPTH - 1);
  localparam logic [CMPW-1:0] CAP_LIMIT = CMPW'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_RET,
    S_ACK
  } state_t;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  kind_t              kind_r, kind_nxt;
  logic               first_r, first_nxt;
  logic [LIMIT_W-1:0] max_entries_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               wr_en, rd_en;
  logic [PW-1:0]      rd_addr;
  logic [MEM_W-1:0]   wr_data, rd_data;
  logic               rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;

  logic               out_free;
  logic [CMPW-1:0]    limit, count_inc;
  logic               take;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign rd_key    = rd_data[MEM_W-1];
  assign rd_handle = rd_data[HANDLE_BITS-1:0];
  assign wr_data   = {in_data.key_flag, HANDLE_BITS'(in_data.packet_handle)};

  kdpq_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(MEM_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(tail_r),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit = (CMPW'(max_entries_r) > CAP_LIMIT) ? CAP_LIMIT : CMPW'(max_entries_r);
  assign count_inc = CMPW'(count_r) + 1'b1;
  // after the first forced drop, only non-key heads keep being dropped
  assign take = (kind_r != KIND_DROPPED) || first_r || !rd_key;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    first_nxt     = first_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            ACT_PUSH: begin
              wr_en     = 1'b1;
              tail_nxt  = next_slot(tail_r);
              count_nxt = count_r + 1'b1;
              first_nxt = 1'b1;
              if (count_inc > limit) begin
                kind_nxt  = KIND_DROPPED;
                state_nxt = S_RD;
              end else begin
                kind_nxt  = KIND_ACK;
                state_nxt = S_ACK;
              end
            end
            ACT_POP: begin
              if (count_r == '0) begin
                kind_nxt  = KIND_EMPTY;
                state_nxt = S_ACK;
              end else begin
                kind_nxt  = KIND_POPPED;
                state_nxt = S_RD;
              end
            end
            ACT_CLEAR: begin
              if (count_r == '0) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                kind_nxt  = KIND_ACK;
                state_nxt = S_ACK;
              end else begin
                kind_nxt  = KIND_CLEARED;
                state_nxt = S_RD;
              end
            end
            ACT_SIZE: begin
              kind_nxt  = KIND_ACK;
              state_nxt = S_ACK;
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_RET;
      end

      S_RET: begin
        if (!take) begin
          kind_nxt  = KIND_ACK;
          state_nxt = S_ACK;
        end else if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.result_kind = kind_r;
          out_data_nxt.out_handle = OUT_HANDLE_W'(rd_handle);
          out_data_nxt.out_key    = rd_key;
          out_data_nxt.occupancy  = OCC_W'(count_r - 1'b1);
          out_data_nxt.last       = (kind_r == KIND_POPPED);
          head_nxt                = next_slot(head_r);
          count_nxt               = count_r - 1'b1;
          first_nxt               = 1'b0;
          if (kind_r == KIND_POPPED) begin
            state_nxt = S_IDLE;
          end else if (count_r == CW'(1)) begin
            if (kind_r == KIND_CLEARED) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
            kind_nxt  = KIND_ACK;
            state_nxt = S_ACK;
          end else begin
            // fetch the next head while this one goes out
            rd_en   = 1'b1;
            rd_addr = next_slot(head_r);
          end
        end
      end

      S_ACK: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_kind = kind_r;
          out_data_nxt.out_handle  = '0;
          out_data_nxt.out_key     = 1'b0;
          out_data_nxt.occupancy   = OCC_W'(count_r);
          out_data_nxt.last        = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      kind_r        <= KIND_ACK;
      first_r       <= 1'b0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      kind_r      <= kind_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_valid && cfg_ready) begin
        max_entries_r <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/kdpq_mem.sv
module kdpq_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
